// File: hw/rtl/bat_pkg.sv
package bat_pkg;

   localparam int NLEN_W = 7;
   localparam int DFLT_LEN = 7;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_REPORT = 2'd1,
      FUNC_READ   = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      OUT_UPDATED = 3'd0,
      OUT_INSERTED = 3'd1,
      OUT_DROPPED = 3'd2,
      OUT_CLEARED = 3'd3,
      OUT_READ_OK = 3'd4,
      OUT_READ_BAD = 3'd5
   } outcome_type;

   localparam logic [7:0] AD_NAME_SHORT = 8'h08;
   localparam logic [7:0] AD_NAME_FULL = 8'h09;

   typedef struct packed {
      logic [47:0] addr;
      logic [7:0] level;
      logic [31:0] seen;
      logic [NLEN_W-1:0] nlen;
   } entry_type;

   typedef struct packed {
      logic found;
      logic [NLEN_W-1:0] ins_len;
   } name_info_type;

   function automatic logic [7:0] dflt_char(input logic [5:0] idx);
      logic [7:0] c;
      case (idx)
         6'd0: c = 8'h55;
         6'd1: c = 8'h6e;
         6'd2: c = 8'h6b;
         6'd3: c = 8'h6e;
         6'd4: c = 8'h6f;
         6'd5: c = 8'h77;
         6'd6: c = 8'h6e;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// File: hw/rtl/bat_ram.sv
module bat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 20,
   parameter int AW = 5
) (
   input logic clock,
   input logic wr_en,
   input logic [AW-1:0] wr_idx,
   input logic [WIDTH-1:0] wr_data,
   input logic rd_en,
   input logic [AW-1:0] rd_idx,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/bat_parser.sv
module bat_parser #(
   parameter int NAME_CHARS = 20,
   parameter int ADV_BYTES = 31,
   parameter int NIW = 5
) (
   input logic clock,
   input logic reset,
   input logic step,
   input logic clr,
   input logic [4:0] adv_length,
   input logic [7:0] adv_byte,
   input logic [NIW-1:0] buf_rd_idx,
   output logic [7:0] buf_rd_data,
   output bat_pkg::name_info_type info
);
   import bat_pkg::*;

   localparam int NLW = $clog2(NAME_CHARS + 1);

   typedef enum logic [3:0] {
      PH_SEEK = 4'b0001,
      PH_TYPE = 4'b0010,
      PH_COPY = 4'b0100,
      PH_DONE = 4'b1000
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [7:0] pos_ff, pos_in;
   logic [8:0] nsp_ff, nsp_in;
   logic [7:0] cur_ff, cur_in;
   logic [NLW-1:0] len_ff, len_in;
   logic found_ff, found_in;
   logic buf_we;
   logic [7:0] name_buf [NAME_CHARS];

   always_comb begin
      phase_in = phase_ff;
      pos_in = pos_ff;
      nsp_in = nsp_ff;
      cur_in = cur_ff;
      len_in = len_ff;
      found_in = found_ff;
      buf_we = 1'b0;
      if (clr) begin
         phase_in = PH_SEEK;
         pos_in = '0;
         nsp_in = '0;
         cur_in = '0;
         len_in = '0;
         found_in = 1'b0;
      end else if (step) begin
         if (pos_ff < {3'b0, adv_length}) begin
            case (phase_ff)
               PH_SEEK: begin
                  if ({1'b0, pos_ff} == nsp_ff) begin
                     if (adv_byte == 8'd0 ||
                         ({1'b0, pos_ff} + {1'b0, adv_byte}) >= {4'b0, adv_length}) begin
                        phase_in = PH_DONE;
                     end else begin
                        cur_in = adv_byte;
                        nsp_in = {1'b0, pos_ff} + {1'b0, adv_byte} + 9'd1;
                        phase_in = PH_TYPE;
                     end
                  end
               end
               PH_TYPE: begin
                  if (adv_byte == AD_NAME_SHORT || adv_byte == AD_NAME_FULL) begin
                     found_in = 1'b1;
                     len_in = '0;
                     phase_in = (cur_ff == 8'd1) ? PH_DONE : PH_COPY;
                  end else begin
                     phase_in = PH_SEEK;
                  end
               end
               PH_COPY: begin
                  if (32'(len_ff) < NAME_CHARS) begin
                     buf_we = 1'b1;
                     len_in = len_ff + NLW'(1);
                  end
                  if (({1'b0, pos_ff} + 9'd1) >= nsp_ff) begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
               end
            endcase
         end
         if (32'(pos_ff) < ADV_BYTES) begin
            pos_in = pos_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK;
         pos_ff <= '0;
         nsp_ff <= '0;
         cur_ff <= '0;
         len_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         nsp_ff <= nsp_in;
         cur_ff <= cur_in;
         len_ff <= len_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         name_buf[NIW'(len_ff)] <= adv_byte;
      end
   end

   assign buf_rd_data = name_buf[buf_rd_idx];
   assign info.found = found_ff;
   assign info.ins_len = found_ff ? NLEN_W'(len_ff)
                        : NLEN_W'((NAME_CHARS < DFLT_LEN) ? NAME_CHARS : DFLT_LEN);
endmodule

// File: hw/rtl/ble_adv_device_table.sv
// A clear beat or a report beat that is not the last leaves the block idle; a clear's result
// beat is valid the cycle after acceptance. A read passes through ST_READ. A last report beat
// walks ST_LOOK and ST_CMP per entry; a hit ends in ST_CMP, a full table drops it in ST_LOOK,
// and an insert runs ST_COPY for NAME_CHARS name characters; its result ends the operation.
// One operation is in flight at a time, and a held result beat stalls the input. Synchronous
// reset empties the table and the parser; RAM contents are not cleared.
module ble_adv_device_table #(
   parameter int TABLE_ENTRIES = 20,
   parameter int NAME_CHARS = 20,
   parameter int ADV_BYTES = 31
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [1:0] req_func,
   input logic [47:0] req_dev_addr,
   input logic signed [7:0] req_signal_level,
   input logic [31:0] req_now_tick,
   input logic [4:0] req_adv_length,
   input logic [7:0] req_adv_byte,
   input logic req_last_byte,
   input logic [4:0] req_read_slot,
   input logic [4:0] req_read_char_pos,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [2:0] rsp_outcome,
   output logic [4:0] rsp_slot,
   output logic [4:0] rsp_entry_count,
   output logic [47:0] rsp_out_addr,
   output logic signed [7:0] rsp_out_level,
   output logic [31:0] rsp_out_seen,
   output logic [7:0] rsp_out_char,
   output logic [4:0] rsp_out_name_len
);
   import bat_pkg::*;

   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int NIW = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
   localparam int NAW = (TABLE_ENTRIES * NAME_CHARS > 1) ?
                        $clog2(TABLE_ENTRIES * NAME_CHARS) : 1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LOOK = 5'b00010,
      ST_CMP  = 5'b00100,
      ST_COPY = 5'b01000,
      ST_READ = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [NIW-1:0] copy_ff, copy_in;
   logic [47:0] key_ff;
   logic [7:0] level_ff;
   logic [31:0] tick_ff;
   logic rd_ok_ff;
   logic [4:0] rslot_ff;
   logic [4:0] rpos_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] outcome_ff, outcome_in;
   logic [4:0] slot_ff, slot_in;
   logic [4:0] cnt_out_ff, cnt_out_in;
   logic [47:0] oaddr_ff, oaddr_in;
   logic [7:0] olevel_ff, olevel_in;
   logic [31:0] oseen_ff, oseen_in;
   logic [7:0] ochar_ff, ochar_in;
   logic [4:0] olen_ff, olen_in;

   logic accept;
   logic emit_free;
   logic parse_step, parse_clr;
   name_info_type info;
   logic [7:0] buf_char;

   logic ent_we, ent_re;
   logic [EW-1:0] ent_wr_idx, ent_rd_idx;
   entry_type ent_wr_data, ent_rd_data;
   logic name_we, name_re;
   logic [NAW-1:0] name_wr_idx, name_rd_idx;
   logic [7:0] name_wr_data, name_rd_data;

   assign accept = req_valid && !req_stall;
   assign emit_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !emit_free;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      copy_in = copy_ff;
      parse_step = 1'b0;
      parse_clr = 1'b0;
      ent_we = 1'b0;
      ent_re = 1'b0;
      ent_wr_idx = EW'(idx_ff);
      ent_rd_idx = EW'(idx_ff);
      ent_wr_data = '{addr: key_ff, level: level_ff, seen: tick_ff, nlen: ent_rd_data.nlen};
      name_we = 1'b0;
      name_re = 1'b0;
      name_wr_idx = NAW'(32'(count_ff) * NAME_CHARS + 32'(copy_ff));
      name_rd_idx = NAW'(32'(EW'(req_read_slot)) * NAME_CHARS + 32'(req_read_char_pos));
      name_wr_data = (NLEN_W'(copy_ff) < info.ins_len) ?
                     (info.found ? buf_char : dflt_char(6'(copy_ff))) : 8'd0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      outcome_in = outcome_ff;
      slot_in = slot_ff;
      cnt_out_in = cnt_out_ff;
      oaddr_in = oaddr_ff;
      olevel_in = olevel_ff;
      oseen_in = oseen_ff;
      ochar_in = ochar_ff;
      olen_in = olen_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_CLEAR: begin
                     count_in = '0;
                     parse_clr = 1'b1;
                     rsp_valid_in = 1'b1;
                     outcome_in = OUT_CLEARED;
                     slot_in = '0;
                     cnt_out_in = '0;
                     oaddr_in = '0;
                     olevel_in = '0;
                     oseen_in = '0;
                     ochar_in = '0;
                     olen_in = '0;
                  end
                  FUNC_REPORT: begin
                     parse_step = 1'b1;
                     if (req_last_byte) begin
                        idx_in = '0;
                        state_in = ST_LOOK;
                     end
                  end
                  FUNC_READ: begin
                     ent_re = 1'b1;
                     ent_rd_idx = EW'(req_read_slot);
                     name_re = 1'b1;
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOOK: begin
            if (idx_ff < count_ff) begin
               ent_re = 1'b1;
               state_in = ST_CMP;
            end else if (32'(count_ff) < TABLE_ENTRIES) begin
               ent_we = 1'b1;
               ent_wr_idx = EW'(count_ff);
               ent_wr_data = '{addr: key_ff, level: level_ff, seen: tick_ff,
                               nlen: info.ins_len};
               copy_in = '0;
               state_in = ST_COPY;
            end else begin
               parse_clr = 1'b1;
               rsp_valid_in = 1'b1;
               outcome_in = OUT_DROPPED;
               slot_in = '0;
               cnt_out_in = 5'(count_ff);
               oaddr_in = '0;
               olevel_in = '0;
               oseen_in = '0;
               ochar_in = '0;
               olen_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_CMP: begin
            if (ent_rd_data.addr == key_ff) begin
               ent_we = 1'b1;
               parse_clr = 1'b1;
               rsp_valid_in = 1'b1;
               outcome_in = OUT_UPDATED;
               slot_in = 5'(idx_ff);
               cnt_out_in = 5'(count_ff);
               oaddr_in = '0;
               olevel_in = '0;
               oseen_in = '0;
               ochar_in = '0;
               olen_in = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + CW'(1);
               state_in = ST_LOOK;
            end
         end
         ST_COPY: begin
            name_we = 1'b1;
            copy_in = copy_ff + NIW'(1);
            if (32'(copy_ff) == NAME_CHARS - 1) begin
               count_in = count_ff + CW'(1);
               parse_clr = 1'b1;
               rsp_valid_in = 1'b1;
               outcome_in = OUT_INSERTED;
               slot_in = 5'(count_ff);
               cnt_out_in = 5'(count_ff + CW'(1));
               oaddr_in = '0;
               olevel_in = '0;
               oseen_in = '0;
               ochar_in = '0;
               olen_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            cnt_out_in = 5'(count_ff);
            if (rd_ok_ff) begin
               outcome_in = OUT_READ_OK;
               slot_in = rslot_ff;
               oaddr_in = ent_rd_data.addr;
               olevel_in = ent_rd_data.level;
               oseen_in = ent_rd_data.seen;
               ochar_in = (NLEN_W'(rpos_ff) < ent_rd_data.nlen &&
                           32'(rpos_ff) < NAME_CHARS) ? name_rd_data : 8'd0;
               olen_in = 5'(ent_rd_data.nlen);
            end else begin
               outcome_in = OUT_READ_BAD;
               slot_in = '0;
               oaddr_in = '0;
               olevel_in = '0;
               oseen_in = '0;
               ochar_in = '0;
               olen_in = '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         idx_ff <= '0;
         copy_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff <= idx_in;
         copy_ff <= copy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= req_dev_addr;
         level_ff <= req_signal_level;
         tick_ff <= req_now_tick;
         rd_ok_ff <= 32'(req_read_slot) < 32'(count_ff);
         rslot_ff <= req_read_slot;
         rpos_ff <= req_read_char_pos;
      end
      outcome_ff <= outcome_in;
      slot_ff <= slot_in;
      cnt_out_ff <= cnt_out_in;
      oaddr_ff <= oaddr_in;
      olevel_ff <= olevel_in;
      oseen_ff <= oseen_in;
      ochar_ff <= ochar_in;
      olen_ff <= olen_in;
   end

   bat_parser #(
      .NAME_CHARS(NAME_CHARS),
      .ADV_BYTES(ADV_BYTES),
      .NIW(NIW)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .step(parse_step),
      .clr(parse_clr),
      .adv_length(req_adv_length),
      .adv_byte(req_adv_byte),
      .buf_rd_idx(copy_ff),
      .buf_rd_data(buf_char),
      .info(info)
   );

   bat_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(TABLE_ENTRIES),
      .AW(EW)
   ) u_entry_ram (
      .clock(clock),
      .wr_en(ent_we),
      .wr_idx(ent_wr_idx),
      .wr_data(ent_wr_data),
      .rd_en(ent_re),
      .rd_idx(ent_rd_idx),
      .rd_data(ent_rd_data)
   );

   bat_ram #(
      .WIDTH(8),
      .DEPTH(TABLE_ENTRIES * NAME_CHARS),
      .AW(NAW)
   ) u_name_ram (
      .clock(clock),
      .wr_en(name_we),
      .wr_idx(name_wr_idx),
      .wr_data(name_wr_data),
      .rd_en(name_re),
      .rd_idx(name_rd_idx),
      .rd_data(name_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_outcome = outcome_ff;
   assign rsp_slot = slot_ff;
   assign rsp_entry_count = cnt_out_ff;
   assign rsp_out_addr = oaddr_ff;
   assign rsp_out_level = olevel_ff;
   assign rsp_out_seen = oseen_ff;
   assign rsp_out_char = ochar_ff;
   assign rsp_out_name_len = olen_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= TABLE_ENTRIES)
      else $error("entry count above table size");

   a_cmp_after_look: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP |-> $past(state_ff) == ST_LOOK)
      else $error("compare without a preceding entry read");

   a_insert_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && outcome_ff == OUT_INSERTED |-> cnt_out_ff == slot_ff + 5'd1)
      else $error("inserted slot does not match entry count");

   a_beat_from_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff != ST_IDLE ||
                                    (accept && req_func == FUNC_CLEAR)))
      else $error("response beat without a finishing operation");
endmodule
